FILE: hw/rtl/tvsf_pkg.sv
package tvsf_pkg;

   localparam int DataBits = 64;
   localparam int CapBits  = 32;
   localparam int CsrAddrBits = 6;

   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } width_type;

   typedef enum logic [2:0] {
      MODE_EXACT        = 3'd0,
      MODE_INCREASED    = 3'd1,
      MODE_DECREASED    = 3'd2,
      MODE_CHANGED      = 3'd3,
      MODE_UNCHANGED    = 3'd4,
      MODE_INCREASED_BY = 3'd5,
      MODE_DECREASED_BY = 3'd6,
      MODE_UNKNOWN      = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      REG_VALUE_WIDTH  = 3'd0,
      REG_COMPARE_MODE = 3'd1,
      REG_TARGET_VALUE = 3'd2,
      REG_DELTA_VALUE  = 3'd3,
      REG_RESULT_CAP   = 3'd4
   } reg_index_type;

   typedef struct packed {
      width_type             value_width;
      mode_type              compare_mode;
      logic [DataBits-1:0]   target_value;
      logic [DataBits-1:0]   delta_value;
      logic [CapBits-1:0]    result_cap;
   } cfg_type;

   function automatic logic [DataBits-1:0] width_mask(input width_type w);
      logic [DataBits-1:0] m;
      case (w)
         WIDTH_8:  m = 64'h0000_0000_0000_00FF;
         WIDTH_16: m = 64'h0000_0000_0000_FFFF;
         WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
         default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

   // sign-extend the low bits at width to one bit past the full data width
   function automatic logic [DataBits:0] sign_extend(input logic [DataBits-1:0] v,
                                                      input width_type w);
      logic [DataBits:0] r;
      case (w)
         WIDTH_8:  r = {{(DataBits-7){v[7]}}, v[7:0]};
         WIDTH_16: r = {{(DataBits-15){v[15]}}, v[15:0]};
         WIDTH_32: r = {{(DataBits-31){v[31]}}, v[31:0]};
         default:  r = {v[DataBits-1], v};
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/tvsf_csr.sv
module tvsf_csr
   import tvsf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CsrAddrBits-1:0] csr_paddr,
   input  logic [DataBits-1:0]    csr_pwdata,
   output logic [DataBits-1:0]    csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg,
   output logic                   cap_write
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CsrAddrBits-1:3]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cap_write  = wr_en & (index == REG_RESULT_CAP);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_VALUE_WIDTH:  cfg_in.value_width  = width_type'(csr_pwdata[1:0]);
            REG_COMPARE_MODE: cfg_in.compare_mode = mode_type'(csr_pwdata[2:0]);
            REG_TARGET_VALUE: cfg_in.target_value = csr_pwdata;
            REG_DELTA_VALUE:  cfg_in.delta_value  = csr_pwdata;
            REG_RESULT_CAP:   cfg_in.result_cap   = csr_pwdata[CapBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_VALUE_WIDTH:  csr_prdata = {{(DataBits-2){1'b0}}, cfg_ff.value_width};
         REG_COMPARE_MODE: csr_prdata = {{(DataBits-3){1'b0}}, cfg_ff.compare_mode};
         REG_TARGET_VALUE: csr_prdata = cfg_ff.target_value;
         REG_DELTA_VALUE:  csr_prdata = cfg_ff.delta_value;
         REG_RESULT_CAP:   csr_prdata = {{(DataBits-CapBits){1'b0}}, cfg_ff.result_cap};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.value_width  <= WIDTH_32;
         cfg_ff.compare_mode <= MODE_EXACT;
         cfg_ff.target_value <= '0;
         cfg_ff.delta_value  <= '0;
         cfg_ff.result_cap   <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/tvsf_compare.sv
module tvsf_compare
   import tvsf_pkg::*;
(
   input  cfg_type             cfg,
   input  logic [DataBits-1:0] new_value,
   input  logic [DataBits-1:0] old_value,
   output logic                hit,
   output logic [DataBits-1:0] new_masked,
   output logic [DataBits-1:0] old_masked
);

   logic [DataBits-1:0] mask;
   logic [DataBits:0]   new_sx;
   logic [DataBits:0]   old_sx;
   logic [DataBits:0]   delta_sx;
   logic [DataBits:0]   step_sum;

   assign mask       = width_mask(cfg.value_width);
   assign new_masked = new_value & mask;
   assign old_masked = old_value & mask;
   assign new_sx     = sign_extend(new_value, cfg.value_width);
   assign old_sx     = sign_extend(old_value, cfg.value_width);
   assign delta_sx   = sign_extend(cfg.delta_value, cfg.value_width);

   // one bit of headroom: an out-of-range step never equals a sign-extended value
   assign step_sum = (cfg.compare_mode == MODE_DECREASED_BY) ? old_sx - delta_sx
                                                             : old_sx + delta_sx;

   always_comb begin
      case (cfg.compare_mode)
         MODE_EXACT:        hit = new_masked == (cfg.target_value & mask);
         MODE_INCREASED:    hit = $signed(new_sx) > $signed(old_sx);
         MODE_DECREASED:    hit = $signed(old_sx) > $signed(new_sx);
         MODE_CHANGED:      hit = new_masked != old_masked;
         MODE_UNCHANGED:    hit = new_masked == old_masked;
         MODE_INCREASED_BY: hit = step_sum == new_sx;
         MODE_DECREASED_BY: hit = step_sum == new_sx;
         default:           hit = 1'b1;
      endcase
   end

endmodule

FILE: hw/rtl/typed_value_scan_filter.sv
// Scan filter for memory-value candidates. Each req beat carries a candidate
// address, new value and old value in req_tdata and the read-ok flag in req_tuser;
// beats with read-ok low are dropped. Survivors of the compare at the configured
// width and mode go out on rsp as one beat with the masked address and the new
// and old values masked to the width, until the match count reaches result_cap
// (writing result_cap clears the count). One candidate is taken per clock unless a
// matching candidate waits on a stalled result; each passes through an input
// register and the compare into the result register.
// Registers sit at byte address 8*index on the 64-bit csr port.
module typed_value_scan_filter
   import tvsf_pkg::*;
#(
   parameter int ADDRESS_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [3*DataBits-1:0]  req_tdata,  // cand_address, new_value, old_value
   input  logic [0:0]             req_tuser,  // read_ok
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [3*DataBits-1:0]  rsp_tdata,  // match_address, current_value, previous_value
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CsrAddrBits-1:0] csr_paddr,
   input  logic [DataBits-1:0]    csr_pwdata,
   output logic [DataBits-1:0]    csr_prdata,
   output logic                   csr_pready
);

   cfg_type                 cfg;
   logic                    cap_write;

   logic                    s1_valid_ff, s1_valid_in;
   logic [ADDRESS_BITS-1:0] s1_addr_ff;
   logic [DataBits-1:0]     s1_new_ff;
   logic [DataBits-1:0]     s1_old_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDRESS_BITS-1:0] rsp_addr_ff;
   logic [DataBits-1:0]     rsp_new_ff;
   logic [DataBits-1:0]     rsp_old_ff;
   logic [DataBits-1:0]     rsp_addr_wide;

   logic [CapBits-1:0]      match_count_ff, match_count_in;

   logic                    hit;
   logic [DataBits-1:0]     new_masked;
   logic [DataBits-1:0]     old_masked;
   logic                    emit;
   logic                    advance;
   logic                    s1_leave;
   logic                    emit_go;
   logic                    req_accept;

   tvsf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cap_write   (cap_write)
   );

   tvsf_compare u_compare (
      .cfg        (cfg),
      .new_value  (s1_new_ff),
      .old_value  (s1_old_ff),
      .hit        (hit),
      .new_masked (new_masked),
      .old_masked (old_masked)
   );

   assign emit     = s1_valid_ff & hit & (match_count_ff < cfg.result_cap);
   assign advance  = ~rsp_valid_ff | rsp_tready;
   // a candidate that produces nothing leaves even while the result is stalled
   assign s1_leave = s1_valid_ff & (advance | ~emit);
   assign emit_go  = emit & advance;

   assign req_tready = ~s1_valid_ff | s1_leave;
   assign req_accept = req_tvalid & req_tready;

   assign s1_valid_in    = req_accept ? req_tuser[0] : (s1_valid_ff & ~s1_leave);
   assign rsp_valid_in   = advance ? emit : rsp_valid_ff;
   assign match_count_in = cap_write ? '0
                         : (emit_go ? match_count_ff + 1'b1 : match_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         match_count_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         match_count_ff <= match_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff <= req_tdata[ADDRESS_BITS-1:0];
         s1_new_ff  <= req_tdata[2*DataBits-1:DataBits];
         s1_old_ff  <= req_tdata[3*DataBits-1:2*DataBits];
      end
      if (emit_go) begin
         rsp_addr_ff <= s1_addr_ff;
         rsp_new_ff  <= new_masked;
         rsp_old_ff  <= old_masked;
      end
   end

   always_comb begin
      rsp_addr_wide = '0;
      rsp_addr_wide[ADDRESS_BITS-1:0] = rsp_addr_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_old_ff, rsp_new_ff, rsp_addr_wide};

   // the count only climbs while below the cap, and a cap write clears it
   a_count_within_cap: assert property (@(posedge clock) disable iff (reset)
      match_count_ff <= cfg.result_cap)
      else $error("match count above result cap");

   a_count_tracks_results: assert property (@(posedge clock) disable iff (reset)
      emit_go && !cap_write |=> match_count_ff == $past(match_count_ff) + 1'b1)
      else $error("match count did not advance with a result");

   a_no_emit_when_capped: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && match_count_ff >= cfg.result_cap && !rsp_valid_ff
      |=> !rsp_valid_ff)
      else $error("result produced past the cap");

endmodule

FILE: tb/tb_typed_value_scan_filter.sv
`timescale 1ns / 100ps

module tb_typed_value_scan_filter;
   import tvsf_pkg::*;

   localparam int          AddrBits     = 64;
   localparam logic [63:0] AddrMask     = (AddrBits >= 64) ? '1 : ((64'd1 << AddrBits) - 64'd1);
   localparam int          SettleCycles = 6;
   localparam int          QuietLimit   = 1000;
   localparam int          PhaseCount   = 13;
   localparam int          PhaseItems   = 100;

   typedef struct {
      logic [63:0] addr;
      logic        ok;
      logic [63:0] new_v;
      logic [63:0] old_v;
   } candidate_type;

   typedef struct {
      logic [63:0] addr;
      logic [63:0] cur;
      logic [63:0] prev;
   } match_type;

   class scan_board_type;
      width_type   width;
      mode_type    mode;
      logic [63:0] target;
      logic [63:0] delta;
      logic [31:0] cap;
      logic [31:0] hits;
      match_type   expected_matches[$];
      int          errors;

      function new();
         width  = WIDTH_32;
         mode   = MODE_EXACT;
         target = '0;
         delta  = '0;
         cap    = '1;
         hits   = '0;
         errors = 0;
      endfunction

      function logic [63:0] value_mask();
         return (64'd1 << (8 << int'(width))) - 64'd1;
      endfunction

      function int pending();
         return expected_matches.size();
      endfunction

      function void write_reg(input reg_index_type idx, input logic [63:0] v);
         case (idx)
            REG_VALUE_WIDTH:  width = width_type'(v[1:0]);
            REG_COMPARE_MODE: mode = mode_type'(v[2:0]);
            REG_TARGET_VALUE: target = v;
            REG_DELTA_VALUE:  delta = v;
            REG_RESULT_CAP: begin
               cap  = v[31:0];
               hits = '0;
            end
            default: ;
         endcase
      endfunction

      // new == old +/- delta at width, rejecting any signed overflow of the sum
      function bit step_hits(input logic [63:0] nv, ov, dv, m, top, input bit down);
         logic [63:0] r;
         bit          so, sd, sr, ovf;
         so  = (ov & top) != 0;
         sd  = (dv & top) != 0;
         r   = (down ? ov - dv : ov + dv) & m;
         sr  = (r & top) != 0;
         ovf = down ? (so != sd && sr != so) : (so == sd && sr != so);
         return !ovf && r == nv;
      endfunction

      function void note_candidate(input candidate_type c);
         logic [63:0] m, top, nv, ov, dv;
         bit          hit;
         match_type   x;
         m   = value_mask();
         top = (m >> 1) + 64'd1;
         nv  = c.new_v & m;
         ov  = c.old_v & m;
         dv  = delta & m;
         if (!c.ok) return;
         case (mode)
            MODE_EXACT:        hit = nv == (target & m);
            MODE_INCREASED:    hit = ((nv ^ top) & m) > ((ov ^ top) & m);
            MODE_DECREASED:    hit = ((ov ^ top) & m) > ((nv ^ top) & m);
            MODE_CHANGED:      hit = nv != ov;
            MODE_UNCHANGED:    hit = nv == ov;
            MODE_INCREASED_BY: hit = step_hits(nv, ov, dv, m, top, 1'b0);
            MODE_DECREASED_BY: hit = step_hits(nv, ov, dv, m, top, 1'b1);
            default:           hit = 1'b1;
         endcase
         if (hit && hits < cap) begin
            hits   = hits + 32'd1;
            x.addr = c.addr & AddrMask;
            x.cur  = nv;
            x.prev = ov;
            expected_matches.insert(expected_matches.size(), x);
         end
      endfunction

      function void check_match(input logic [3*DataBits-1:0] d);
         match_type want;
         if (expected_matches.size() == 0) begin
            $error("unexpected result: match_address %h", d[63:0]);
            errors++;
            return;
         end
         want = expected_matches.pop_front();
         if (d[63:0] !== want.addr) begin
            $error("match_address: expected %h, actual %h", want.addr, d[63:0]);
            errors++;
         end
         if (d[127:64] !== want.cur) begin
            $error("current_value: expected %h, actual %h", want.cur, d[127:64]);
            errors++;
         end
         if (d[191:128] !== want.prev) begin
            $error("previous_value: expected %h, actual %h", want.prev, d[191:128]);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [3*DataBits-1:0]  req_tdata;  // cand_address, new_value, old_value
   logic [0:0]             req_tuser;  // read_ok
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [3*DataBits-1:0]  rsp_tdata;  // match_address, current_value, previous_value
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CsrAddrBits-1:0] csr_paddr;
   logic [DataBits-1:0]    csr_pwdata;
   logic [DataBits-1:0]    csr_prdata;
   logic                   csr_pready;

   scan_board_type  sb = new();
   bit              tx_eager = 1'b0;
   bit              rx_eager = 1'b0;
   int              quiet_cycles = 0;

   typed_value_scan_filter #(
      .ADDRESS_BITS(AddrBits)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("** typed_value_scan_filter: FAILED **");
         $finish;
      end
   end

   // result sink: after each beat, drop ready for a random stall unless running eager
   initial begin : rsp_sink
      int stall;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_match(rsp_tdata);
            stall = rx_eager ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [63:0] edge_value(input logic [63:0] m, input logic [63:0] top);
      case ($urandom_range(0, 5))
         0:       return 64'd0;
         1:       return m;
         2:       return top;
         3:       return top - 64'd1;
         4:       return 64'($urandom_range(0, 3));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // mostly candidates shaped to land near a hit for the current mode
   function automatic candidate_type make_candidate();
      candidate_type c;
      logic [63:0]   m, top, step;
      int            s;
      m       = sb.value_mask();
      top     = (m >> 1) + 64'd1;
      s       = int'($urandom_range(0, 4)) - 2;
      step    = 64'(s);
      c.addr  = {$urandom, $urandom};
      c.ok    = ($urandom_range(0, 9) != 0);
      c.old_v = edge_value(m, top);
      c.new_v = {$urandom, $urandom};
      if ($urandom_range(0, 9) < 6) begin
         case (sb.mode)
            MODE_EXACT:                     c.new_v = sb.target;
            MODE_CHANGED, MODE_UNCHANGED:   c.new_v = c.old_v + 64'($urandom_range(0, 1));
            MODE_INCREASED, MODE_DECREASED: c.new_v = c.old_v + step;
            MODE_INCREASED_BY:              c.new_v = c.old_v + sb.delta;
            MODE_DECREASED_BY:              c.new_v = c.old_v - sb.delta;
            default: ;
         endcase
      end
      c.new_v = (c.new_v & m) | ({$urandom, $urandom} & ~m);
      c.old_v = (c.old_v & m) | ({$urandom, $urandom} & ~m);
      return c;
   endfunction

   task automatic send_candidate(input candidate_type c);
      int gap;
      gap = tx_eager ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c.old_v, c.new_v, c.addr};
      req_tuser  <= c.ok;
      do @(posedge clock); while (!req_tready);
      sb.note_candidate(c);
   endtask

   task automatic send_fields(input logic [63:0] addr, input logic ok,
                              input logic [63:0] new_v, input logic [63:0] old_v);
      candidate_type c;
      c.addr  = addr;
      c.ok    = ok;
      c.new_v = new_v;
      c.old_v = old_v;
      send_candidate(c);
   endtask

   // drop valid, wait for every pending match, then let the pipeline empty
   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [63:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrBits'({idx, 3'b000});
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, v);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(input mode_type md);
      quiesce();
      csr_write(REG_COMPARE_MODE, 64'(md));
   endtask

   initial begin : stimulus
      width_type   w;
      mode_type    md;
      logic [63:0] m, top, v;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      reset       <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 32-bit exact against zero
      send_fields(64'd0, 1'b1, 64'd0, 64'd0);
      send_fields('1, 1'b1, '1, '1);
      send_fields('1, 1'b0, 64'd0, 64'd0);

      quiesce();
      csr_write(REG_VALUE_WIDTH, 64'(WIDTH_8));
      csr_write(REG_TARGET_VALUE, 64'hFFFF_FFFF_FFFF_FF80);
      csr_write(REG_DELTA_VALUE, 64'd1);
      send_fields(64'hA5A5_0000_0000_0001, 1'b1, 64'h1234_5680, 64'd0);
      send_fields(64'd2, 1'b1, 64'h7F, 64'h80);
      set_mode(MODE_INCREASED);
      send_fields(64'd3, 1'b1, 64'h80, 64'h7F);
      send_fields(64'd4, 1'b1, 64'h7F, 64'h80);
      send_fields(64'd5, 1'b1, 64'hFF77, 64'hAA77);
      set_mode(MODE_DECREASED);
      send_fields(64'd6, 1'b1, 64'h80, 64'h7F);
      set_mode(MODE_CHANGED);
      send_fields(64'd7, 1'b1, 64'h105, 64'h205);
      send_fields(64'd8, 1'b1, 64'h06, 64'h05);
      set_mode(MODE_UNCHANGED);
      send_fields(64'd9, 1'b1, 64'h105, 64'h205);
      // +1 from the signed maximum overflows, -1 + 1 wraps cleanly to zero
      set_mode(MODE_INCREASED_BY);
      send_fields(64'd10, 1'b1, 64'h80, 64'h7F);
      send_fields(64'd11, 1'b1, 64'h00, 64'hFF);
      set_mode(MODE_DECREASED_BY);
      send_fields(64'd12, 1'b1, 64'h7F, 64'h80);
      send_fields(64'd13, 1'b1, 64'hFF, 64'h00);
      set_mode(MODE_UNKNOWN);
      csr_write(REG_RESULT_CAP, 64'd2);
      send_fields(64'd14, 1'b1, 64'd1, 64'd2);
      send_fields(64'd15, 1'b1, 64'd3, 64'd4);
      send_fields(64'd16, 1'b1, 64'd5, 64'd6);
      quiesce();
      csr_write(REG_RESULT_CAP, 64'd0);
      send_fields(64'd17, 1'b1, 64'd7, 64'd8);
      quiesce();
      csr_write(REG_RESULT_CAP, 64'hFFFF_FFFF);
      csr_write(REG_VALUE_WIDTH, 64'(WIDTH_64));
      set_mode(MODE_INCREASED);
      send_fields(64'd18, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
      quiesce();
      csr_write(REG_DELTA_VALUE, 64'h8000_0000_0000_0000);
      set_mode(MODE_INCREASED_BY);
      send_fields(64'd19, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, '1);
      send_fields(64'd20, 1'b1, 64'h8000_0000_0000_0000, 64'd0);

      for (int p = 0; p < PhaseCount; p++) begin
         quiesce();
         w  = (p < 4) ? width_type'(p) : width_type'($urandom_range(0, 3));
         md = (p < 8) ? mode_type'(p) : mode_type'($urandom_range(0, 7));
         // junk in the unused upper bits must be ignored
         csr_write(REG_VALUE_WIDTH, ({$urandom, $urandom} & ~64'h3) | 64'(w));
         csr_write(REG_COMPARE_MODE, ({$urandom, $urandom} & ~64'h7) | 64'(md));
         case ($urandom_range(0, 2))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
         endcase
         csr_write(REG_TARGET_VALUE, v);
         m   = sb.value_mask();
         top = (m >> 1) + 64'd1;
         case ($urandom_range(0, 3))
            0:       v = 64'(int'($urandom_range(0, 8)) - 4);
            1:       v = top;
            2:       v = top - 64'd1;
            default: v = {$urandom, $urandom};
         endcase
         csr_write(REG_DELTA_VALUE, v);
         v[31:0]  = ($urandom_range(0, 4) == 0) ? 32'($urandom_range(0, 40)) : 32'hFFFF_FFFF;
         v[63:32] = $urandom;
         csr_write(REG_RESULT_CAP, v);
         tx_eager = ($urandom_range(0, 3) == 0);
         rx_eager = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PhaseItems; i++) begin
            if (i == PhaseItems / 2 || $urandom_range(0, 99) == 0)
               quiesce();
            send_candidate(make_candidate());
         end
      end

      quiesce();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("** typed_value_scan_filter: PASSED **");
      else
         $display("** typed_value_scan_filter: FAILED **");
      $finish;
   end

endmodule
